>>> hw/rtl/fslot_pkg.sv
// fslot_pkg: request/response payload types, command/status structs and codes
// shared by the frame slot manager controller, datapath and top level.
// No dependencies.
`default_nettype none

package fslot_pkg;

    localparam logic [1:0] ACT_WRITE     = 2'd0;
    localparam logic [1:0] ACT_READ      = 2'd1;
    localparam logic [1:0] ACT_END       = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOTHING    = 2'd1;
    localparam logic [1:0] ST_NO_SLOT    = 2'd2;

    typedef enum logic [1:0] {
        MODE_FREE    = 2'd0,
        MODE_NEW     = 2'd1,
        MODE_READING = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] frame_value;
        logic [3:0]  slot_index;
    } t_req;

    typedef struct packed {
        logic [3:0]  chosen_slot;
        logic [31:0] read_value;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> hw/rtl/fslot_dp.sv
// fslot_dp: slot mode flags, frame value memory, oldest-new scan unit and
// output register of the frame slot manager. Depends on fslot_pkg.
`default_nettype none

module fslot_dp
    import fslot_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    input  wire  i_out_ready,
    output t_sts o_sts,
    output logic o_out_valid,
    output t_rsp o_out_rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (IW > 4) ? IW : 4;
    localparam logic [CW-1:0] LAST = CW'(SLOTS);

    t_mode       r_mode [SLOTS];
    logic [31:0] r_mem  [SLOTS];

    t_req        r_req;
    logic [CW-1:0] r_addr;
    logic        r_cmp_valid;
    logic        r_cmp_new;
    logic [IW-1:0] r_cmp_idx;
    logic [31:0] r_rd_data;
    logic        r_best_valid;
    logic [IW-1:0] r_best_idx;
    logic [31:0] r_best_val;
    logic        r_out_valid;
    t_rsp        r_out;

    logic          has_free;
    logic [IW-1:0] free_idx;
    logic [XW-1:0] end_idx;
    logic          end_in_range;
    logic          issue;
    logic          take;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    t_rsp          n_out;

    always_comb begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_mode[i] == MODE_FREE) begin
                has_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign end_idx      = XW'(r_req.slot_index);
    assign end_in_range = (32'(r_req.slot_index) < 32'(SLOTS));
    assign issue        = i_cmd.scan_step && (r_addr != LAST);
    assign take         = r_cmp_valid && r_cmp_new &&
                          (!r_best_valid || (r_rd_data < r_best_val));

    always_comb begin
        n_out  = '0;
        wr_en  = 1'b0;
        wr_idx = '0;
        case (r_req.action)
            ACT_WRITE: begin
                if (has_free) begin
                    wr_en  = 1'b1;
                    wr_idx = free_idx;
                end else if (r_best_valid) begin
                    wr_en  = 1'b1;
                    wr_idx = r_best_idx;
                end else begin
                    n_out.status = ST_NO_SLOT;
                end
                if (wr_en) begin
                    n_out.chosen_slot = 4'(XW'(wr_idx));
                end
            end
            ACT_READ: begin
                if (r_best_valid) begin
                    n_out.chosen_slot = 4'(XW'(r_best_idx));
                    n_out.read_value  = r_best_val;
                end else begin
                    n_out.status = ST_NOTHING;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr[IW-1:0]];
            r_cmp_idx <= r_addr[IW-1:0];
            r_cmp_new <= (r_mode[r_addr[IW-1:0]] == MODE_NEW);
        end
        if (take) begin
            r_best_idx <= r_cmp_idx;
            r_best_val <= r_rd_data;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
            if (wr_en && r_req.action == ACT_WRITE) begin
                r_mem[wr_idx] <= r_req.frame_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_mode[i] <= MODE_FREE;
            end
            r_addr       <= '0;
            r_cmp_valid  <= 1'b0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_addr       <= '0;
                r_cmp_valid  <= 1'b0;
                r_best_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_valid <= issue;
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (take) begin
                    r_best_valid <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_best_valid <= 1'b0;
                r_out_valid  <= 1'b1;
                case (r_req.action)
                    ACT_WRITE: begin
                        if (wr_en) begin
                            r_mode[wr_idx] <= MODE_NEW;
                        end
                    end
                    ACT_READ: begin
                        if (r_best_valid) begin
                            r_mode[r_best_idx] <= MODE_READING;
                        end
                    end
                    ACT_END: begin
                        if (end_in_range) begin
                            r_mode[end_idx[IW-1:0]] <= MODE_FREE;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.need_scan = (r_req.action == ACT_READ) ||
                             ((r_req.action == ACT_WRITE) && !has_free);
    assign o_sts.scan_done = (r_addr == LAST) && !r_cmp_valid;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_rsp       = r_out;

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not load output register");

    a_best_is_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_valid |-> (r_mode[r_best_idx] == MODE_NEW))
        else $error("scan best slot is not in new mode");

    a_free_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_req.action == ACT_WRITE && has_free) |=>
            (r_out.status == ST_OK))
        else $error("write with free slot reported an error");

endmodule

`default_nettype wire

>>> hw/rtl/fslot_ctrl.sv
// fslot_ctrl: request sequencing for the frame slot manager (accept, decide,
// scan, commit). Depends on fslot_pkg.
`default_nettype none

module fslot_ctrl
    import fslot_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while output register is occupied");

endmodule

`default_nettype wire

>>> hw/rtl/frame_slot_manager.sv
// frame_slot_manager: top level, joins the controller and the datapath.
// Depends on fslot_pkg, fslot_ctrl, fslot_dp.
//
// Handles one request at a time. An end read, a no-op and a write that finds a
// free slot pass from the decide state to the done state with no scan. A begin
// read, and a write when no slot is free, scan the frame value memory one slot
// per cycle through its single registered read port to find the oldest new
// frame. Each result sits in an output register, so the next request is taken
// while it waits to be collected. Slot modes reset to free; stored values need
// no reset.
`default_nettype none

module frame_slot_manager
    import fslot_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_rsp o_out_rsp
);

    t_cmd cmd;
    t_sts sts;

    fslot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fslot_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench: self-checking bench for frame_slot_manager, tracks slot modes and frame
// values to predict each response; directed cases, then random bursts under idling
// and stalls. Depends on fslot_pkg and frame_slot_manager.
module testbench;
    import fslot_pkg::*;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
    localparam logic [1:0] ACT_NOP = 2'd3;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_req in_req = '0;
    logic in_ready;
    logic out_valid;
    t_rsp out_rsp;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    t_mode slot_state [SLOTS];
    logic [31:0] slot_frame [SLOTS];
    t_rsp awaited_rsp[$];
    t_rsp want_rsp;

    frame_slot_manager #(.SLOTS(SLOTS)) dut (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_req(in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_rsp(out_rsp)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL frame_slot_manager");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // slot tracking
    function automatic int first_free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (slot_state[i] == MODE_FREE) return i;
        return -1;
    endfunction

    function automatic int oldest_new_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_state[i] == MODE_NEW && (best < 0 || slot_frame[i] < slot_frame[best]))
                best = i;
        return best;
    endfunction

    task automatic apply_slot_request(input t_req req);
        t_rsp rsp;
        int pick;
        rsp = '0;
        case (req.action)
            ACT_WRITE: begin
                pick = first_free_slot();
                if (pick < 0) pick = oldest_new_slot();
                if (pick < 0) begin
                    rsp.status = ST_NO_SLOT;
                end else begin
                    slot_frame[pick] = req.frame_value;
                    slot_state[pick] = MODE_NEW;
                    rsp.chosen_slot = pick[3:0];
                end
            end
            ACT_READ: begin
                pick = oldest_new_slot();
                if (pick < 0) begin
                    rsp.status = ST_NOTHING;
                end else begin
                    slot_state[pick] = MODE_READING;
                    rsp.chosen_slot = pick[3:0];
                    rsp.read_value = slot_frame[pick];
                end
            end
            ACT_END: begin
                if (int'(req.slot_index) < SLOTS) slot_state[req.slot_index] = MODE_FREE;
            end
            default: ;
        endcase
        awaited_rsp.push_back(rsp);
    endtask

    // response check
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited_rsp.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected response: slot %0d value %h status %0d",
                             out_rsp.chosen_slot, out_rsp.read_value, out_rsp.status);
            end else begin
                want_rsp = awaited_rsp.pop_front();
                if (out_rsp.chosen_slot !== want_rsp.chosen_slot ||
                    out_rsp.read_value !== want_rsp.read_value ||
                    out_rsp.status !== want_rsp.status) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display({"mismatch: exp slot %0d value %h status %0d, ",
                                  "got slot %0d value %h status %0d"},
                                 want_rsp.chosen_slot, want_rsp.read_value, want_rsp.status,
                                 out_rsp.chosen_slot, out_rsp.read_value, out_rsp.status);
                end
            end
        end
    end

    task automatic send_request(input t_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        apply_slot_request(req);
    endtask

    function automatic t_req make_req(input logic [1:0] act, input logic [31:0] val,
                                      input logic [3:0] idx);
        t_req req;
        req.action = act;
        req.frame_value = val;
        req.slot_index = idx;
        return req;
    endfunction

    function automatic logic [31:0] random_frame();
        case ($urandom_range(3))
            1: return $urandom_range(7);
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] release_target();
        int held[$];
        for (int i = 0; i < SLOTS; i++)
            if (slot_state[i] == MODE_READING) held.push_back(i);
        if (held.size() == 0 || $urandom_range(4) == 0) return 4'($urandom_range(15));
        return 4'(held[$urandom_range(held.size() - 1)]);
    endfunction

    // burst flavor: 0 write-heavy, 1 read-heavy, 2 release-heavy, 3 mixed
    function automatic t_req random_request(input int flavor);
        t_req req;
        int r, w_lim, rd_lim, e_lim;
        case (flavor)
            0: begin w_lim = 75; rd_lim = 88; e_lim = 96; end
            1: begin w_lim = 15; rd_lim = 75; e_lim = 95; end
            2: begin w_lim = 30; rd_lim = 50; e_lim = 95; end
            default: begin w_lim = 40; rd_lim = 70; e_lim = 95; end
        endcase
        r = $urandom_range(99);
        req = make_req(ACT_NOP, $urandom, 4'($urandom_range(15)));
        if (r < w_lim) begin
            req.action = ACT_WRITE;
            req.frame_value = random_frame();
        end else if (r < rd_lim) begin
            req.action = ACT_READ;
        end else if (r < e_lim) begin
            req.action = ACT_END;
            req.slot_index = release_target();
        end
        return req;
    endfunction

    task automatic test_basic_ops();
        send_request(make_req(ACT_WRITE, 32'hFFFF_FFFF, 4'hF));
        send_request(make_req(ACT_WRITE, 32'h0, 4'h0));
        send_request(make_req(ACT_READ, 32'hFFFF_FFFF, 4'hF));
        send_request(make_req(ACT_READ, 32'h0, 4'h0));
        send_request(make_req(ACT_READ, 32'h5A5A_5A5A, 4'h3));
        send_request(make_req(ACT_END, 32'h0, 4'd1));
        send_request(make_req(ACT_END, 32'hFFFF_FFFF, 4'd0));
        send_request(make_req(ACT_NOP, 32'hFFFF_FFFF, 4'hF));
        send_request(make_req(ACT_END, 32'h0, 4'hF));
        send_request(make_req(ACT_WRITE, 32'hA5A5_A5A5, 4'h0));
        // release of a slot still new
        send_request(make_req(ACT_END, 32'h0, 4'd0));
    endtask

    task automatic test_overwrite_oldest();
        send_request(make_req(ACT_WRITE, 32'hFFFF_FFFF, 4'h0));
        for (int i = 1; i < SLOTS; i++)
            send_request(make_req(ACT_WRITE, $urandom_range(1, 3), 4'h0));
        // ties on the smallest value go to the lowest index
        send_request(make_req(ACT_WRITE, 32'h8000_0000, 4'h0));
    endtask

    task automatic test_all_reading();
        for (int i = 0; i < SLOTS; i++)
            send_request(make_req(ACT_READ, 32'h0, 4'h0));
        send_request(make_req(ACT_WRITE, 32'h1234_5678, 4'h0));
        send_request(make_req(ACT_READ, 32'h0, 4'h0));
        send_request(make_req(ACT_END, 32'h0, 4'hF));
        send_request(make_req(ACT_WRITE, 32'h0000_0042, 4'h0));
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int done, flavor, burst;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_items) begin
            flavor = $urandom_range(3);
            burst = $urandom_range(4, 24);
            for (int k = 0; k < burst; k++)
                send_request(random_request(flavor));
            done += burst;
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_state[i] = MODE_FREE;
            slot_frame[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_overwrite_oldest();
        test_all_reading();
        test_random_traffic(125, 0, 0);
        test_random_traffic(125, 71, 0);
        test_random_traffic(125, 0, 71);
        test_random_traffic(125, 24, 24);
        wait_for_drain();

        if (mismatch_count == 0 && awaited_rsp.size() == 0)
            $display("PASS frame_slot_manager");
        else
            $display("FAIL frame_slot_manager");
        $finish;
    end
endmodule
